### hdl/btb_lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btb_lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 10;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int FILL_W     = $clog2(ENTRIES + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;

  typedef struct packed {
    logic [31:0]           address;
    logic [31:0]           target;
    logic                  taken;
    logic [COUNT_BITS-1:0] count;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

### hdl/btb_lfu_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module btb_lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/branch_target_buffer_lfu_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative branch target buffer with least-use replacement.
// Input channel (in_valid / in_stall) carries func, pc, target_address and
// taken_in; func selects lookup, insert or update. Output channel
// (out_valid / out_stall) returns next_pc, hit and predicted_taken, one
// result per input transfer, in order.
// All slots live in one single-port-read RAM. After a transfer the unit
// reads every slot once through one comparator, looking for the first
// matching valid slot and the first slot with the lowest use count. A
// drain state takes the last read, then the slot is written back and the
// result is loaded into the output register. The unit takes no new item
// until the current one has been scanned and written back.
// in_stall is high while an item is in work. When out_stall holds a result,
// the unit still accepts and scans the next item and waits before write-back
// until the output register frees.
// Reset empties the buffer (fill count zero) and drops any pending result;
// slot contents need no clearing since only filled slots are compared.

module branch_target_buffer_lfu_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] target_address,
  input  wire logic        taken_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] next_pc,
  output logic             hit,
  output logic             predicted_taken
);

  import btb_lfu_pkg::*;

  state_t state, state_next;

  logic [1:0]  req_func;
  logic [31:0] req_pc;
  logic [31:0] req_target;
  logic        req_taken;

  logic [FILL_W-1:0] fill_count;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  chk_idx;
  logic              chk_valid;

  logic              found;
  logic [IDX_W-1:0]  match_idx;
  slot_t             match_slot;
  logic [IDX_W-1:0]  victim_idx;
  logic [COUNT_BITS-1:0] min_count;

  slot_t             rd_slot;
  logic [SLOT_W-1:0] rd_data;
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_t             wr_slot;

  logic              in_xfer;
  logic              finish;
  logic              full;
  logic              chk_in_fill;
  logic              chk_match;
  logic [31:0]       pc_plus4;

  btb_lfu_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_slot),
    .rd_en  (rd_en),
    .rd_addr(rd_idx),
    .rd_data(rd_data)
  );

  assign rd_slot     = slot_t'(rd_data);
  assign in_stall    = (state != ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign finish      = (state == ST_DONE) && (!out_valid || !out_stall);
  assign full        = (fill_count == FILL_W'(ENTRIES));
  assign rd_en       = (state == ST_SCAN);
  assign chk_in_fill = (FILL_W'(chk_idx) < fill_count);
  assign chk_match   = chk_valid && chk_in_fill && (rd_slot.address == req_pc);
  assign pc_plus4    = req_pc + 32'd4;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_SCAN;
      ST_SCAN:  if (rd_idx == IDX_W'(ENTRIES - 1)) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = match_idx;
    wr_slot = match_slot;
    if (finish) begin
      case (req_func)
        FUNC_LOOKUP: begin
          wr_en = found;
          if (match_slot.count != COUNT_MAX) begin
            wr_slot.count = match_slot.count + COUNT_BITS'(1);
          end
        end
        FUNC_INSERT: begin
          wr_en           = 1'b1;
          wr_addr         = full ? victim_idx : fill_count[IDX_W-1:0];
          wr_slot.address = req_pc;
          wr_slot.target  = req_target;
          wr_slot.taken   = req_taken;
          wr_slot.count   = COUNT_BITS'(1);
        end
        FUNC_UPDATE: begin
          wr_en         = found;
          wr_slot.taken = req_taken;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      chk_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= rd_en;
      if (finish && (req_func == FUNC_INSERT) && !full) begin
        fill_count <= fill_count + FILL_W'(1);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_func   <= func;
      req_pc     <= pc;
      req_target <= target_address;
      req_taken  <= taken_in;
      rd_idx     <= '0;
      found      <= 1'b0;
    end
    if (rd_en) begin
      rd_idx  <= rd_idx + IDX_W'(1);
      chk_idx <= rd_idx;
    end
    if (chk_valid) begin
      if (chk_match && !found) begin
        found      <= 1'b1;
        match_idx  <= chk_idx;
        match_slot <= rd_slot;
      end
      if ((chk_idx == '0) || (rd_slot.count < min_count)) begin
        min_count  <= rd_slot.count;
        victim_idx <= chk_idx;
      end
    end
    if (finish) begin
      hit             <= found;
      predicted_taken <= found && match_slot.taken;
      if ((req_func == FUNC_LOOKUP) && found && match_slot.taken) begin
        next_pc <= match_slot.target;
      end else begin
        next_pc <= pc_plus4;
      end
    end
  end

endmodule

`default_nettype wire
